@@ rtl/nx32_pkg.sv @@
// Shared types and round functions for the NORX32 permutation pipeline.
// Used by nx32_round_stage and norx32_permutation; depends on nothing.
package nx32_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned NWORDS   = 16;
  localparam int unsigned STATE_W  = WORD_W * NWORDS;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned ROUND_W  = 5;
  localparam int unsigned RCNT_W   = ROUND_W + 1;
  localparam logic [ROUND_W-1:0] ROUND_RESET = ROUND_W'(4);

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NWORDS-1:0] state_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t hmix(word_t x, word_t y);
    hmix = x ^ y ^ ((x & y) << 1);
  endfunction

  function automatic word_t rotr(word_t x, int unsigned r);
    rotr = (x >> r) | (x << (WORD_W - r));
  endfunction

  function automatic quad_t gfun(word_t a_in, word_t b_in, word_t c_in, word_t d_in);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    a = hmix(a_in, b_in);
    d = rotr(d_in ^ a, 8);
    c = hmix(c_in, d);
    b = rotr(b_in ^ c, 11);
    a = hmix(a, b);
    d = rotr(d ^ a, 16);
    c = hmix(c, d);
    b = rotr(b ^ c, 31);
    gfun = '{a: a, b: b, c: c, d: d};
  endfunction

  // Column step: G on (0,4,8,12) (1,5,9,13) (2,6,10,14) (3,7,11,15).
  function automatic state_t col_step(state_t s);
    state_t o;
    quad_t  q;
    o = s;
    for (int i = 0; i < 4; i++) begin
      q = gfun(s[i], s[i+4], s[i+8], s[i+12]);
      o[i]    = q.a;
      o[i+4]  = q.b;
      o[i+8]  = q.c;
      o[i+12] = q.d;
    end
    col_step = o;
  endfunction

  // Diagonal step: G on (0,5,10,15) (1,6,11,12) (2,7,8,13) (3,4,9,14).
  function automatic state_t diag_step(state_t s);
    state_t o;
    quad_t  q;
    o = s;
    for (int i = 0; i < 4; i++) begin
      q = gfun(s[i], s[4 + ((i + 1) % 4)], s[8 + ((i + 2) % 4)], s[12 + ((i + 3) % 4)]);
      o[i]                  = q.a;
      o[4 + ((i + 1) % 4)]  = q.b;
      o[8 + ((i + 2) % 4)]  = q.c;
      o[12 + ((i + 3) % 4)] = q.d;
    end
    diag_step = o;
  endfunction

endpackage

@@ rtl/nx32_round_stage.sv @@
// One pipeline stage: a column or a diagonal step of one round, registered.
// The step is skipped when the round lies beyond the active round count.
// Depends on nx32_pkg.
module nx32_round_stage import nx32_pkg::*; #(
  parameter bit          DIAG      = 1'b0,
  parameter int unsigned ROUND_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  state_t            in_state_i,
  input  logic [RCNT_W-1:0] rounds_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output state_t            out_state_o
);

  logic   valid_q;
  state_t state_q;
  state_t state_d;
  logic   active;

  assign active     = rounds_i > RCNT_W'(ROUND_IDX);
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    if (!active) begin
      state_d = in_state_i;
    end else if (DIAG) begin
      state_d = diag_step(in_state_i);
    end else begin
      state_d = col_step(in_state_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_state_o = state_q;

endmodule

@@ rtl/norx32_permutation.sv @@
// Top level of the NORX32 permutation: a chain of half-round pipeline stages.
// Depends on nx32_pkg and nx32_round_stage.
//
//   channel  | direction | payload
//   s_axis   | in        | tdata: words 0..15 (word 0 lowest); tuser: domain tag
//   m_axis   | out       | tdata: permuted words 0..15 (word 0 lowest)
//   cfg      | in        | data: round count
//
// The pipeline has 2*MAX_ROUNDS register stages, one per column or diagonal
// step, and one item enters per cycle while the output is not stalled.
// Steps beyond the configured round count pass the state through unchanged.
// Each stage holds its item while the next is full and stalled; empty stages
// keep taking items. Reset empties all stages and sets the round count to 4.
module norx32_permutation import nx32_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [STATE_W-1:0] s_axis_tdata,  // words 0..15, 32 bits each
  input  logic [TAG_W-1:0]   s_axis_tuser,  // domain tag
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [STATE_W-1:0] m_axis_tdata,  // words 0..15, 32 bits each
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ROUND_W-1:0] cfg_data_i
);

  localparam int unsigned NSTAGES = 2 * MAX_ROUNDS;

  logic [ROUND_W-1:0] round_count_q;
  logic [RCNT_W-1:0]  rounds;
  state_t             in_state;

  logic   valid [NSTAGES+1];
  logic   ready [NSTAGES+1];
  state_t st    [NSTAGES+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= ROUND_RESET;
    end else if (cfg_valid_i) begin
      round_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (RCNT_W'(round_count_q) > RCNT_W'(MAX_ROUNDS)) begin
      rounds = RCNT_W'(MAX_ROUNDS);
    end else begin
      rounds = RCNT_W'(round_count_q);
    end
  end

  always_comb begin
    in_state     = state_t'(s_axis_tdata);
    in_state[15] = in_state[15] ^ WORD_W'(s_axis_tuser);
  end

  assign valid[0]      = s_axis_tvalid;
  assign st[0]         = in_state;
  assign s_axis_tready = ready[0];

  for (genvar k = 0; k < NSTAGES; k++) begin : g_stage
    nx32_round_stage #(
      .DIAG      ((k % 2) == 1),
      .ROUND_IDX (k / 2)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[k]),
      .in_ready_o  (ready[k]),
      .in_state_i  (st[k]),
      .rounds_i    (rounds),
      .out_valid_o (valid[k+1]),
      .out_ready_i (ready[k+1]),
      .out_state_o (st[k+1])
    );
  end

  assign ready[NSTAGES] = m_axis_tready;
  assign m_axis_tvalid  = valid[NSTAGES];
  assign m_axis_tdata   = STATE_W'(st[NSTAGES]);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for norx32_permutation: a directed table, then random-item
// phases at several round counts, checked against a NORX32 permutation predictor.
// Depends on nx32_pkg and the norx32_permutation RTL.
`timescale 1ns / 1ps

module tb_top import nx32_pkg::*; ();

  localparam int unsigned ROUNDS_MAX = 16;
  localparam int unsigned PIPE_DEPTH = 2 * ROUNDS_MAX;
  localparam int unsigned N_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned CALM_ITEMS = 30;
  localparam int unsigned N_DIRECTED = 20;

  typedef struct {
    logic [ROUND_W-1:0] rounds;
    logic [STATE_W-1:0] data;
    logic [TAG_W-1:0]   tag;
    bit                 known;
    logic [STATE_W-1:0] want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [STATE_W-1:0] s_axis_tdata;
  logic [TAG_W-1:0]   s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [STATE_W-1:0] m_axis_tdata;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [ROUND_W-1:0] cfg_data_i;

  logic [STATE_W-1:0] perm_expected_q[$];
  logic [ROUND_W-1:0] rounds_now;
  dir_row_t           dir_rows[N_DIRECTED];
  bit                 calm;
  int                 fail_count;

  norx32_permutation #(
    .MAX_ROUNDS(ROUNDS_MAX)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  function automatic logic [31:0] carry_mix(input logic [31:0] x, input logic [31:0] y);
    return x ^ y ^ ((x & y) << 1);
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void quarter_mix(inout logic [31:0] a, inout logic [31:0] b,
                                      inout logic [31:0] c, inout logic [31:0] d);
    a = carry_mix(a, b);
    d = ror32(d ^ a, 8);
    c = carry_mix(c, d);
    b = ror32(b ^ c, 11);
    a = carry_mix(a, b);
    d = ror32(d ^ a, 16);
    c = carry_mix(c, d);
    b = ror32(b ^ c, 31);
  endfunction

  function automatic logic [STATE_W-1:0] norx_permute(input logic [STATE_W-1:0] st,
                                                      input logic [TAG_W-1:0] tag,
                                                      input logic [ROUND_W-1:0] rounds);
    logic [31:0]        w[16];
    logic [STATE_W-1:0] res;
    int                 n;
    for (int i = 0; i < 16; i++) w[i] = st[32*i +: 32];
    w[15] = w[15] ^ {24'h0, tag};
    n = (rounds > ROUNDS_MAX) ? ROUNDS_MAX : int'(rounds);
    for (int r = 0; r < n; r++) begin
      quarter_mix(w[0], w[4], w[8], w[12]);
      quarter_mix(w[1], w[5], w[9], w[13]);
      quarter_mix(w[2], w[6], w[10], w[14]);
      quarter_mix(w[3], w[7], w[11], w[15]);
      quarter_mix(w[0], w[5], w[10], w[15]);
      quarter_mix(w[1], w[6], w[11], w[12]);
      quarter_mix(w[2], w[7], w[8], w[13]);
      quarter_mix(w[3], w[4], w[9], w[14]);
    end
    for (int i = 0; i < 16; i++) res[32*i +: 32] = w[i];
    return res;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 7));
  endfunction

  // Called at a rising edge; returns at the edge where the item was taken.
  task automatic send_item(input logic [STATE_W-1:0] data, input logic [TAG_W-1:0] tag,
                           input logic [STATE_W-1:0] want);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= tag;
    do @(posedge clk_i); while (!s_axis_tready);
    perm_expected_q.push_back(want);
  endtask

  // The round count only changes once the pipeline has emptied.
  task automatic write_rounds(input logic [ROUND_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (perm_expected_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rounds_now = value;
  endtask

  task automatic check_result(input logic [STATE_W-1:0] got);
    logic [STATE_W-1:0] want;
    int                 bad;
    if (perm_expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("Unexpected result item: %h", got);
    end else begin
      want = perm_expected_q.pop_front();
      bad = -1;
      for (int f = 0; f < 8; f++) begin
        if (bad < 0 && got[64*f +: 64] !== want[64*f +: 64]) bad = f;
      end
      if (bad >= 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Mismatch in out_words_%0d_%0d: expected %h, got %h", 2 * bad,
                   2 * bad + 1, want[64*bad +: 64], got[64*bad +: 64]);
        end
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int stall;
    @(negedge rst_ni);
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_result(m_axis_tdata);
    end
  end

  initial begin
    logic [STATE_W-1:0] data;
    logic [STATE_W-1:0] want;
    logic [TAG_W-1:0]   tag;
    logic [ROUND_W-1:0] setting;
    int                 pick;

    rst_ni        = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    calm          = 1'b0;
    fail_count    = 0;
    rounds_now    = 5'd4;
    #1 rst_ni     = 1'b0;

    // An all-zero state with no domain byte is a fixed point for any round count.
    dir_rows[0]  = '{5'd4, '0, 8'h00, 1'b1, '0};
    dir_rows[1]  = '{5'd4, '1, 8'hff, 1'b0, '0};
    dir_rows[2]  = '{5'd4, {8{64'hfedcba98_76543210}}, 8'h5a, 1'b0, '0};
    dir_rows[3]  = '{5'd0, {8{64'h0123_4567_89ab_cdef}}, 8'h00, 1'b1,
                     {8{64'h0123_4567_89ab_cdef}}};
    dir_rows[4]  = '{5'd0, '1, 8'hff, 1'b1, {24'hffffff, 8'h00, {480{1'b1}}}};
    dir_rows[5]  = '{5'd0, '0, 8'hff, 1'b1, {24'h0, 8'hff, 480'h0}};
    dir_rows[6]  = '{5'd0, {8{64'hfedcba98_76543210}}, 8'ha5, 1'b1,
                     {8{64'hfedcba98_76543210}} ^ {24'h0, 8'ha5, 480'h0}};
    dir_rows[7]  = '{5'd1, '0, 8'h00, 1'b1, '0};
    dir_rows[8]  = '{5'd1, '1, 8'h00, 1'b0, '0};
    dir_rows[9]  = '{5'd1, {{511{1'b0}}, 1'b1}, 8'h00, 1'b0, '0};
    dir_rows[10] = '{5'd16, '0, 8'h00, 1'b1, '0};
    dir_rows[11] = '{5'd16, '1, 8'hff, 1'b0, '0};
    dir_rows[12] = '{5'd16, {8{64'h0f1e2d3c_4b5a6978}}, 8'h01, 1'b0, '0};
    dir_rows[13] = '{5'd17, {8{64'h0f1e2d3c_4b5a6978}}, 8'h01, 1'b0, '0};
    dir_rows[14] = '{5'd31, '1, 8'h00, 1'b0, '0};
    dir_rows[15] = '{5'd31, '0, 8'h01, 1'b0, '0};
    dir_rows[16] = '{5'd8, {16{32'h8000_0000}}, 8'h80, 1'b0, '0};
    dir_rows[17] = '{5'd8, {16{32'haaaa_aaaa}}, 8'h55, 1'b0, '0};
    dir_rows[18] = '{5'd4, '0, 8'h00, 1'b1, '0};
    dir_rows[19] = '{5'd4, {16{32'h5555_5555}}, 8'h80, 1'b0, '0};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].rounds != rounds_now) write_rounds(dir_rows[i].rounds);
      want = dir_rows[i].known ? dir_rows[i].want
                               : norx_permute(dir_rows[i].data, dir_rows[i].tag, rounds_now);
      send_item(dir_rows[i].data, dir_rows[i].tag, want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: setting = 5'd1;
        1: setting = 5'd16;
        2: setting = 5'd0;
        3: setting = 5'd31;
        default: setting = ROUND_W'($urandom_range(0, 31));
      endcase
      write_rounds(setting);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        calm = (k < CALM_ITEMS);
        pick = $urandom_range(0, 31);
        for (int j = 0; j < 16; j++) data[32*j +: 32] = $urandom();
        if (pick == 0) data = '0;
        else if (pick == 1) data = '1;
        else if (pick == 2) data = {{480{1'b0}}, data[31:0]};
        tag = TAG_W'($urandom());
        if (pick == 3) tag = '0;
        else if (pick == 4) tag = '1;
        send_item(data, tag, norx_permute(data, tag, rounds_now));
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (perm_expected_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
